// ===== hw/rtl/rgbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the RGB 3x3 convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int MaxWidth    = 1024;
  localparam int HeightLimit = 1024;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int DimW        = 11;
  localparam int RowW        = 11;
  localparam int CountW      = 21;
  localparam int TotalW      = 2 * DimW;
  localparam int ChanW       = 8;
  localparam int PixW        = 3 * ChanW;
  localparam int SumW        = 13;
  localparam int BlurW       = 12;
  localparam int BlurProdW   = 24;
  localparam int BlurRecip   = 3641;
  localparam int BlurShift   = 15;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 11;

  typedef enum logic [1:0] {
    KmSharpen = 2'd0,
    KmEmboss  = 2'd1,
    KmBlur    = 2'd2,
    KmEdge    = 2'd3
  } kernel_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKernelMode  = 2'd0,
    CfgMaxLevel    = 2'd1,
    CfgFrameWidth  = 2'd2,
    CfgFrameHeight = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OpPixel = 1'b0,
    OpDrain = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             frame_end;
  } out_item_t;

  // nine taps of one channel, index row * 3 + column
  typedef logic [8:0][ChanW-1:0] tap_win_t;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [ColW-1:0] addr;
    logic            produce;
    logic            frame_end;
    logic [2:0]      row_ok;
    logic [2:0]      col_ok;
  } stage_t;

endpackage

// ===== hw/rtl/rgbc_kernel.sv =====
// ----------------------------------------------------------------------------
// rgbc_kernel
// One channel of the 3x3 kernel: weighted sum, blur divide and clamp.
// ----------------------------------------------------------------------------
module rgbc_kernel (
  input  rgbc_pkg::kernel_mode_e      mode_i,
  input  logic [rgbc_pkg::ChanW-1:0]  max_level_i,
  input  rgbc_pkg::tap_win_t          taps_i,
  output logic [rgbc_pkg::ChanW-1:0]  value_o
);
  import rgbc_pkg::*;

  logic signed [SumW-1:0]  s [9];
  logic signed [SumW-1:0]  sum;
  logic [BlurW-1:0]        blur_sum;
  logic [BlurProdW-1:0]    blur_prod;
  logic [ChanW-1:0]        blur_q;

  always_comb begin
    blur_sum = '0;
    for (int k = 0; k < 9; k++) begin
      s[k]     = signed'(SumW'(taps_i[k]));
      blur_sum = blur_sum + BlurW'(taps_i[k]);
    end
    blur_prod = BlurProdW'(blur_sum) * BlurProdW'(BlurRecip);
    blur_q    = blur_prod[BlurShift +: ChanW];

    unique case (mode_i)
      KmSharpen: sum = (s[4] <<< 2) + s[4] - s[1] - s[3] - s[5] - s[7];
      KmEmboss:  sum = (s[0] <<< 1) + s[1] + s[3] + s[4] - s[5] - s[7] - (s[8] <<< 1);
      KmBlur:    sum = signed'(SumW'(blur_q));
      KmEdge:    sum = s[0] + s[3] + s[6] - s[2] - s[5] - s[8];
    endcase

    if (sum < 0) begin
      value_o = '0;
    end else if (sum > signed'(SumW'(max_level_i))) begin
      value_o = max_level_i;
    end else begin
      value_o = sum[ChanW-1:0];
    end
  end

endmodule

// ===== hw/rtl/rgb_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// Streaming 3x3 convolution of RGB pixels with line stores and window.
// ----------------------------------------------------------------------------
// Takes one item per clock and keeps that rate without gaps while the
// output is not stalled: an accepted item is registered in the window stage,
// where the two line store memories return the column read at acceptance,
// and its result is registered in the output register when the stage moves
// on, from where it transfers once the output is not stalled. Output
// pixels lag the input stream by one row plus one pixel;
// after the last pixel of a frame, drain items flush the pixels still
// pending. Each line store has one read and one write per cycle; a read that
// hits the column being written in the same cycle is forwarded.
module rgb_convolution_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rgbc_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rgbc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [rgbc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rgbc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rgbc_pkg::*;

  kernel_mode_e     kernel_mode_q;
  logic [ChanW-1:0] max_level_q;
  logic [DimW-1:0]  frame_width_q;
  logic [DimW-1:0]  frame_height_q;

  logic [ColW-1:0]   in_column_q, in_column_d;
  logic [RowW-1:0]   in_row_q, in_row_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  logic [PixW-1:0] line_a_mem [MaxWidth];
  logic [PixW-1:0] line_b_mem [MaxWidth];
  logic [PixW-1:0] rd_a_q, rd_b_q;
  logic            fwd_q;
  logic [PixW-1:0] fwd_a_q, fwd_b_q;
  logic [PixW-1:0] cur_a, cur_b;

  logic [2:0][2:0][PixW-1:0] win_q;

  stage_t    s_q, s_d;
  logic      s_valid_q;
  logic      s_move;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      out_free;
  logic      in_accept;

  logic [DimW-1:0]   eff_w, eff_h, pos_c, ocol, next_c;
  logic [RowW-1:0]   pos_r, orow;
  logic [CountW-1:0] cnt;
  logic [TotalW-1:0] total;
  logic              restart, drain_ok, adv, has_cnt, produce;

  tap_win_t [2:0]   taps;
  logic [ChanW-1:0] red_val, green_val, blue_val;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_mode_q  <= KmSharpen;
      max_level_q    <= 8'd255;
      frame_width_q  <= DimW'(MaxWidth);
      frame_height_q <= DimW'(HeightLimit);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgKernelMode:  kernel_mode_q  <= kernel_mode_e'(cfg_wdata_i[1:0]);
        CfgMaxLevel:    max_level_q    <= cfg_wdata_i[ChanW-1:0];
        CfgFrameWidth:  frame_width_q  <= cfg_wdata_i[DimW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_wdata_i[DimW-1:0];
      endcase
    end
  end

  // stream position and result decision at acceptance
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = DimW'(1);
    end else if (frame_width_q > DimW'(MaxWidth)) begin
      eff_w = DimW'(MaxWidth);
    end else begin
      eff_w = frame_width_q;
    end
    if (frame_height_q == '0) begin
      eff_h = DimW'(1);
    end else if (frame_height_q > DimW'(HeightLimit)) begin
      eff_h = DimW'(HeightLimit);
    end else begin
      eff_h = frame_height_q;
    end
    total = TotalW'(eff_w) * TotalW'(eff_h);

    restart  = (in_row_q >= eff_h) || (DimW'(in_column_q) >= eff_w);
    drain_ok = (in_row_q >= eff_h) && (DimW'(in_column_q) < eff_w)
               && (TotalW'(out_count_q) < total);

    if (in_item_i.op == OpPixel && restart) begin
      pos_c = '0;
      pos_r = '0;
      cnt   = '0;
    end else begin
      pos_c = DimW'(in_column_q);
      pos_r = in_row_q;
      cnt   = out_count_q;
    end
    adv     = (in_item_i.op == OpPixel) || drain_ok;
    has_cnt = TotalW'(cnt) < total;

    if (pos_c == '0) begin
      produce = has_cnt && (pos_r >= RowW'(2));
      orow    = pos_r - RowW'(2);
      ocol    = eff_w - DimW'(1);
    end else begin
      produce = has_cnt && (pos_r >= RowW'(1));
      orow    = pos_r - RowW'(1);
      ocol    = pos_c - DimW'(1);
    end

    s_d.addr      = pos_c[ColW-1:0];
    s_d.produce   = produce;
    s_d.frame_end = (TotalW'(cnt) + TotalW'(1)) == total;
    s_d.row_ok[0] = orow != '0;
    s_d.row_ok[1] = 1'b1;
    s_d.row_ok[2] = ((RowW+1)'(orow) + (RowW+1)'(1)) < (RowW+1)'(eff_h);
    s_d.col_ok[0] = ocol != '0;
    s_d.col_ok[1] = 1'b1;
    s_d.col_ok[2] = ((DimW+1)'(ocol) + (DimW+1)'(1)) < (DimW+1)'(eff_w);
    s_d.pix       = (in_item_i.op == OpPixel)
                    ? {in_item_i.in_red, in_item_i.in_green, in_item_i.in_blue}
                    : '0;

    next_c = pos_c + DimW'(1);
    if (next_c >= eff_w) begin
      in_column_d = '0;
      in_row_d    = pos_r + RowW'(1);
    end else begin
      in_column_d = next_c[ColW-1:0];
      in_row_d    = pos_r;
    end
    out_count_d = cnt + CountW'(produce);
  end

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s_move     = s_valid_q && (!s_q.produce || out_free);
  assign in_stall_o = s_valid_q && !s_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q <= '0;
      in_row_q    <= '0;
      out_count_q <= '0;
    end else if (in_accept && adv) begin
      in_column_q <= in_column_d;
      in_row_q    <= in_row_d;
      out_count_q <= out_count_d;
    end
  end

  // line stores
  assign cur_a = fwd_q ? fwd_a_q : rd_a_q;
  assign cur_b = fwd_q ? fwd_b_q : rd_b_q;

  always_ff @(posedge clk_i) begin
    if (s_move) begin
      line_a_mem[s_q.addr] <= s_q.pix;
      line_b_mem[s_q.addr] <= cur_a;
    end
    if (in_accept && adv) begin
      rd_a_q  <= line_a_mem[s_d.addr];
      rd_b_q  <= line_b_mem[s_d.addr];
      fwd_a_q <= s_q.pix;
      fwd_b_q <= cur_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (in_accept && adv) begin
      fwd_q <= s_move && (s_q.addr == s_d.addr);
    end
  end

  // window stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_accept && adv) begin
      s_valid_q <= 1'b1;
    end else if (s_move) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && adv) begin
      s_q <= s_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s_move) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= cur_b;
      win_q[1][2] <= cur_a;
      win_q[2][2] <= s_q.pix;
    end
  end

  // taps of the shifted window, out-of-frame neighbours forced to zero
  always_comb begin
    logic [PixW-1:0] px;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j < 2) begin
          px = win_q[i][j+1];
        end else if (i == 0) begin
          px = cur_b;
        end else if (i == 1) begin
          px = cur_a;
        end else begin
          px = s_q.pix;
        end
        if (!(s_q.row_ok[i] && s_q.col_ok[j])) begin
          px = '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
          taps[ch][i*3+j] = px[(2-ch)*ChanW +: ChanW];
        end
      end
    end
  end

  rgbc_kernel u_kernel_red (
    .mode_i      (kernel_mode_q),
    .max_level_i (max_level_q),
    .taps_i      (taps[0]),
    .value_o     (red_val)
  );

  rgbc_kernel u_kernel_green (
    .mode_i      (kernel_mode_q),
    .max_level_i (max_level_q),
    .taps_i      (taps[1]),
    .value_o     (green_val)
  );

  rgbc_kernel u_kernel_blue (
    .mode_i      (kernel_mode_q),
    .max_level_i (max_level_q),
    .taps_i      (taps[2]),
    .value_o     (blue_val)
  );

  // output register
  always_comb begin
    out_d.out_red   = red_val;
    out_d.out_green = green_val;
    out_d.out_blue  = blue_val;
    out_d.frame_end = s_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_move && s_q.produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_move && s_q.produce) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_stall_needs_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s_valid_q)
    else $error("input stalled with an empty window stage");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s_valid_q && s_q.produce))
    else $error("result appeared without a producing item in the window stage");

  a_stage_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_valid_q) |-> $past(in_accept))
    else $error("window stage filled without an input transfer");

endmodule
